// ===== sv/kps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, register indexes, reset values and the key character table
// for the matrix keypad scanner.
// ----------------------------------------------------------------------------
package kps_pkg;

    // field widths
    localparam int unsigned ROW_W      = 4;
    localparam int unsigned COL_W      = 4;
    localparam int unsigned IDX_W      = 2;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned PIN_W      = 16;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned TIMER_W    = 10;
    localparam int unsigned SHORT_W    = 8;
    localparam int unsigned CFG_DATA_W = 10;

    // default geometry
    localparam int unsigned DEF_COLUMNS    = 4;
    localparam int unsigned DEF_ROWS       = 4;
    localparam int unsigned DEF_PIN_LENGTH = 4;

    // saturation point of the phase timer
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // register reset values
    localparam logic [SHORT_W-1:0] RST_SETTLE   = 8'd5;
    localparam logic [TIMER_W-1:0] RST_DEBOUNCE = 10'd50;
    localparam logic [SHORT_W-1:0] RST_POLL     = 8'd5;
    localparam logic [TIMER_W-1:0] RST_BUZZ     = 10'd20;

    // ascii range of the decimal digits
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;

    // register indexes on the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_SETTLE   = 2'd0,
        REG_DEBOUNCE = 2'd1,
        REG_POLL     = 2'd2,
        REG_BUZZ     = 2'd3
    } t_reg_idx;

    // configuration register set
    typedef struct packed {
        logic [SHORT_W-1:0] settle;
        logic [TIMER_W-1:0] debounce;
        logic [SHORT_W-1:0] poll;
        logic [TIMER_W-1:0] buzz;
    } t_cfg;

    // released key report from the scanner
    typedef struct packed {
        logic              valid;
        logic [1:0]        row;
        logic [1:0]        col;
        logic [CHAR_W-1:0] chr;
        logic              is_digit;
    } t_key_evt;

    // one result item
    typedef struct packed {
        logic [COL_W-1:0]   column_drive;
        logic               key_valid;
        logic [CHAR_W-1:0]  key_char;
        logic [1:0]         key_row;
        logic [1:0]         key_column;
        logic               key_is_digit;
        logic               buzzer_on;
        logic               pin_valid;
        logic [PIN_W-1:0]   pin_digits;
        logic [COUNT_W-1:0] digits_held;
    } t_result;

    // character printed on the key at a column and row
    function automatic logic [CHAR_W-1:0] key_char(input logic [1:0] col,
                                                   input logic [1:0] row);
        logic [CHAR_W-1:0] c;
        unique case ({col, row})
            4'b00_00: c = 7'h31; // '1'
            4'b00_01: c = 7'h32; // '2'
            4'b00_10: c = 7'h33; // '3'
            4'b00_11: c = 7'h41; // 'A'
            4'b01_00: c = 7'h34; // '4'
            4'b01_01: c = 7'h35; // '5'
            4'b01_10: c = 7'h36; // '6'
            4'b01_11: c = 7'h42; // 'B'
            4'b10_00: c = 7'h37; // '7'
            4'b10_01: c = 7'h38; // '8'
            4'b10_10: c = 7'h39; // '9'
            4'b10_11: c = 7'h43; // 'C'
            4'b11_00: c = 7'h2A; // '*'
            4'b11_01: c = 7'h30; // '0'
            4'b11_10: c = 7'h23; // '#'
            default:  c = 7'h44; // 'D'
        endcase
        return c;
    endfunction

endpackage

// ===== sv/kps_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_cfg
// Timing register file written through the configuration port.
// ----------------------------------------------------------------------------
module kps_cfg
    import kps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (t_reg_idx'(i_index))
                REG_SETTLE:   n_cfg.settle   = i_data[SHORT_W-1:0];
                REG_DEBOUNCE: n_cfg.debounce = i_data[TIMER_W-1:0];
                REG_POLL:     n_cfg.poll     = i_data[SHORT_W-1:0];
                REG_BUZZ:     n_cfg.buzz     = i_data[TIMER_W-1:0];
                default:      n_cfg          = r_cfg;
            endcase
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle   <= RST_SETTLE;
            r_cfg.debounce <= RST_DEBOUNCE;
            r_cfg.poll     <= RST_POLL;
            r_cfg.buzz     <= RST_BUZZ;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/kps_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_scan
// Column scan, debounce, release poll and buzzer phases, one tick per
// accepted item. Gives the column drive and buzzer level after the tick
// and the released key, if any.
// ----------------------------------------------------------------------------
module kps_scan
    import kps_pkg::*;
#(
    parameter int unsigned COLUMNS = DEF_COLUMNS,
    parameter int unsigned ROWS    = DEF_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic [ROW_W-1:0] i_row_levels,
    input  t_cfg             i_cfg,
    output t_key_evt         o_key,
    output logic [COL_W-1:0] o_column_drive,
    output logic             o_buzzer_on
);

    typedef enum logic [1:0] {
        PH_SETTLE,
        PH_DEBOUNCE,
        PH_HOLD,
        PH_BUZZ
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_col, n_col;
    logic [1:0]         r_row, n_row;
    logic [TIMER_W-1:0] r_timer, n_timer;

    logic [TIMER_W-1:0] timer_inc;
    logic [2:0]         col_inc;
    logic [2:0]         low_from_zero;
    logic [2:0]         low_above;
    t_key_evt           key;

    // lowest low row at or above a start row, {found, index}
    function automatic logic [2:0] find_low(input logic [ROW_W-1:0] lv,
                                            input logic [2:0]       from);
        logic [2:0] res;
        res = '0;
        for (int r = ROW_W - 1; r >= 0; r--) begin
            if (3'(r) >= from && r < int'(ROWS) && !lv[r]) begin
                res = {1'b1, 2'(r)};
            end
        end
        return res;
    endfunction

    // saturating tick counter and row search
    assign timer_inc     = (r_timer != TIMER_MAX) ? r_timer + 1'b1 : r_timer;
    assign col_inc       = {1'b0, r_col} + 3'd1;
    assign low_from_zero = find_low(i_row_levels, 3'd0);
    assign low_above     = find_low(i_row_levels, {1'b0, r_row} + 3'd1);

    // next phase
    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_timer = timer_inc;
        key     = '0;
        unique case (r_phase)
            PH_DEBOUNCE: begin
                if (timer_inc >= i_cfg.debounce) begin
                    if (!i_row_levels[r_row]) begin
                        n_phase = PH_HOLD;
                        n_timer = '0;
                    end else if (low_above[2]) begin
                        n_row   = low_above[1:0];
                        n_timer = '0;
                    end else begin
                        n_col   = (col_inc >= 3'(COLUMNS)) ? 2'd0 : col_inc[1:0];
                        n_phase = PH_SETTLE;
                        n_timer = '0;
                    end
                end
            end
            PH_HOLD: begin
                if (timer_inc >= {2'b00, i_cfg.poll}) begin
                    n_timer = '0;
                    if (i_row_levels[r_row]) begin
                        key.valid    = 1'b1;
                        key.row      = r_row;
                        key.col      = r_col;
                        key.chr      = key_char(r_col, r_row);
                        key.is_digit = (key.chr >= CHAR_ZERO) && (key.chr <= CHAR_NINE);
                        n_col        = 2'd0;
                        n_phase      = (i_cfg.buzz != '0) ? PH_BUZZ : PH_SETTLE;
                    end
                end
            end
            PH_BUZZ: begin
                if (timer_inc >= i_cfg.buzz) begin
                    n_phase = PH_SETTLE;
                    n_col   = 2'd0;
                    n_timer = '0;
                end
            end
            default: begin
                if (timer_inc >= {2'b00, i_cfg.settle}) begin
                    if (low_from_zero[2]) begin
                        n_row   = low_from_zero[1:0];
                        n_phase = PH_DEBOUNCE;
                        n_timer = '0;
                    end else begin
                        n_col   = (col_inc >= 3'(COLUMNS)) ? 2'd0 : col_inc[1:0];
                        n_timer = '0;
                    end
                end
            end
        endcase
    end

    // scan state, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SETTLE;
            r_col   <= 2'd0;
            r_row   <= 2'd0;
            r_timer <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_timer <= n_timer;
        end
    end

    // outputs reflect the state after this tick
    assign o_key          = key;
    assign o_buzzer_on    = (n_phase == PH_BUZZ);
    assign o_column_drive = (n_phase == PH_BUZZ) ? '1 : ~(COL_W'(1) << n_col);

endmodule

// ===== sv/kps_pin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pin
// Gathers digit keys into a BCD PIN and reports it when complete.
// ----------------------------------------------------------------------------
module kps_pin
    import kps_pkg::*;
#(
    parameter int unsigned PIN_LENGTH = DEF_PIN_LENGTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  t_key_evt           i_key,
    output logic               o_pin_valid,
    output logic [PIN_W-1:0]   o_pin_digits,
    output logic [COUNT_W-1:0] o_digits_held
);

    logic [PIN_W-1:0]   r_shift, n_shift;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [PIN_W-1:0]   shifted;
    logic [COUNT_W-1:0] count_inc;
    logic               done;

    // shift in the new digit, last digit in the low nibble
    assign shifted   = {r_shift[PIN_W-5:0], 4'(i_key.chr - CHAR_ZERO)};
    assign count_inc = r_count + 1'b1;
    assign done      = i_key.valid && i_key.is_digit && (count_inc >= COUNT_W'(PIN_LENGTH));

    always_comb begin
        n_shift = r_shift;
        n_count = r_count;
        if (i_key.valid && i_key.is_digit) begin
            if (done) begin
                n_shift = '0;
                n_count = '0;
            end else begin
                n_shift = shifted;
                n_count = count_inc;
            end
        end
    end

    // pin accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_count <= '0;
        end else if (i_tick) begin
            r_shift <= n_shift;
            r_count <= n_count;
        end
    end

    assign o_pin_valid   = done;
    assign o_pin_digits  = done ? shifted : '0;
    assign o_digits_held = n_count;

endmodule

// ===== sv/kps_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_out_buf
// Two-entry result buffer: an output register and a skid register, so a
// tick can be taken while one result still waits downstream.
// ----------------------------------------------------------------------------
module kps_out_buf
    import kps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_valid && !r_skid_valid;
    assign out_xfer = r_main_valid && !i_stall;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_xfer) begin
                r_main_valid <= r_skid_valid || in_xfer;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= r_main_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (in_xfer) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

// ===== sv/matrix_keypad_scanner_pin_entry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_pin_entry
// 4x4 matrix keypad scanner with debounce, release detection, buzzer pulse
// and BCD PIN gathering, advanced by one tick item per transfer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  tick in   input      i_in_valid / o_in_stall     i_row_levels
//  result    output     o_out_valid / i_out_stall   o_column_drive .. o_digits_held
//  config    input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One tick per cycle while the input is not stalled: the phase logic runs
//  between the scan state and the result buffer, and the result is registered in the output or skid register.
//  The two-entry result buffer accepts a tick while one result waits; the
//  input stalls only when both entries are full.
//  Synchronous active-low reset returns the scan to the settle phase on
//  column zero with the default timing registers and an empty PIN.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_pin_entry
    import kps_pkg::*;
#(
    parameter int unsigned COLUMNS    = DEF_COLUMNS,
    parameter int unsigned ROWS       = DEF_ROWS,
    parameter int unsigned PIN_LENGTH = DEF_PIN_LENGTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ROW_W-1:0]      i_row_levels,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COL_W-1:0]      o_column_drive,
    output logic                  o_key_valid,
    output logic [CHAR_W-1:0]     o_key_char,
    output logic [1:0]            o_key_row,
    output logic [1:0]            o_key_column,
    output logic                  o_key_is_digit,
    output logic                  o_buzzer_on,
    output logic                  o_pin_valid,
    output logic [PIN_W-1:0]      o_pin_digits,
    output logic [COUNT_W-1:0]    o_digits_held,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_key_evt key;
    t_result  res_in;
    t_result  res_out;
    logic     tick;
    logic     in_stall;
    logic [COL_W-1:0]   drive;
    logic               buzz;
    logic               pin_valid;
    logic [PIN_W-1:0]   pin_digits;
    logic [COUNT_W-1:0] digits_held;

    assign o_cfg_ready = 1'b1;
    assign tick        = i_in_valid && !in_stall;

    // timing registers
    kps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // scan phases
    kps_scan #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_row_levels   (i_row_levels),
        .i_cfg          (cfg),
        .o_key          (key),
        .o_column_drive (drive),
        .o_buzzer_on    (buzz)
    );

    // pin gathering
    kps_pin #(
        .PIN_LENGTH (PIN_LENGTH)
    ) u_pin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick),
        .i_key         (key),
        .o_pin_valid   (pin_valid),
        .o_pin_digits  (pin_digits),
        .o_digits_held (digits_held)
    );

    // assemble the result item
    always_comb begin
        res_in.column_drive = drive;
        res_in.key_valid    = key.valid;
        res_in.key_char     = key.chr;
        res_in.key_row      = key.row;
        res_in.key_column   = key.col;
        res_in.key_is_digit = key.is_digit;
        res_in.buzzer_on    = buzz;
        res_in.pin_valid    = pin_valid;
        res_in.pin_digits   = pin_digits;
        res_in.digits_held  = digits_held;
    end

    // result buffer
    kps_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (in_stall),
        .i_data  (res_in),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (res_out)
    );

    assign o_in_stall     = in_stall;
    assign o_column_drive = res_out.column_drive;
    assign o_key_valid    = res_out.key_valid;
    assign o_key_char     = res_out.key_char;
    assign o_key_row      = res_out.key_row;
    assign o_key_column   = res_out.key_column;
    assign o_key_is_digit = res_out.key_is_digit;
    assign o_buzzer_on    = res_out.buzzer_on;
    assign o_pin_valid    = res_out.pin_valid;
    assign o_pin_digits   = res_out.pin_digits;
    assign o_digits_held  = res_out.digits_held;

`ifndef SYNTH
    // a completed pin comes from a digit key and empties the count
    a_pin_from_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pin_valid) |-> (o_key_is_digit && o_digits_held == '0))
        else $error("pin completed without a digit key");

    // all columns released while the buzzer sounds
    a_buzz_columns_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_buzzer_on) |-> (o_column_drive == '1))
        else $error("column driven during buzzer pulse");

    // the key just reported starts the buzzer when its length is nonzero
    a_key_starts_buzz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_valid && cfg.buzz != '0) |-> o_buzzer_on)
        else $error("key reported without buzzer pulse");

    // the input stalls only with a result waiting at the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");
`endif

endmodule
